>>> rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bounding sphere accumulator package
// Shared constants, opcodes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CoordW          = 32;
  localparam int unsigned MagW            = 33;
  localparam int unsigned ProdW           = 66;
  localparam int unsigned RemW            = 36;
  localparam int unsigned GrowW           = 35;
  localparam int unsigned SqrtSteps       = 33;
  localparam int unsigned CntW            = 6;

  typedef enum logic [1:0] {
    OP_RESET_PT  = 2'd0,
    OP_GROW_PT   = 2'd1,
    OP_GROW_SPH  = 2'd2,
    OP_QUERY     = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_PT, S_CP, S_GE, S_MX, S_MY, S_MZ, S_MA, S_MB, S_MC,
    S_SQRT, S_NR, S_GR, S_DINIT, S_DIV, S_TX, S_TY, S_TZ, S_TW, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    MUL_DX, MUL_DY, MUL_DZ, MUL_R, MUL_RD, MUL_SUM, MUL_TX, MUL_TY, MUL_TZ
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    UPD_NONE, UPD_POINT, UPD_COPY, UPD_X, UPD_Y, UPD_Z
  } upd_e;

  typedef enum logic [1:0] {
    GR_HOLD, GR_IN, GR_CUR, GR_NR
  } gr_e;

  typedef struct packed {
    logic     load_in;
    logic     diff_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     cont_en;
    logic     ov_en;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     g_en;
    logic     div_init;
    logic     div_step;
    upd_e     upd;
    gr_e      gr_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic cur_empty;
    logic in_empty;
    logic in_gt_cur;
    logic cont;
  } sts_t;

endpackage

>>> rtl/bsa_if.sv
// ----------------------------------------------------------------------------
// Bounding sphere accumulator channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface bsa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_radius;

  modport source (output valid, op, in_x, in_y, in_z, in_radius, input ready);
  modport sink (input valid, op, in_x, in_y, in_z, in_radius, output ready);
endinterface

interface bsa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] sphere_radius;
  logic               overlaps;
  logic signed [31:0] growth;

  modport source (output valid, center_x, center_y, center_z, sphere_radius, overlaps,
                  growth, input ready);
  modport sink (input valid, center_x, center_y, center_z, sphere_radius, overlaps,
                growth, output ready);
endinterface

>>> rtl/bounding_sphere_accumulator_core.sv
// ----------------------------------------------------------------------------
// Bounding sphere accumulator core
// One Q16.16 bounding sphere updated by reset, grow, merge and query items.
// ----------------------------------------------------------------------------
// A grow or merge that must move the sphere runs a 33-step square root and a
// FRAC_BITS+1 step divide; a query that must measure growth runs the root only.
// Items are handled one at a time; the next item is taken while a result waits.
// Reset: asynchronous active low; sphere becomes empty at the origin.
module bounding_sphere_accumulator_core #(
  parameter int unsigned FRAC_BITS = bsa_pkg::FracBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsa_in_if.sink    in_i,
  bsa_out_if.source out_o
);

  bsa_pkg::cmd_t cmd;
  bsa_pkg::sts_t sts;

  bsa_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsa_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (in_i.op),
    .in_x_i          (in_i.in_x),
    .in_y_i          (in_i.in_y),
    .in_z_i          (in_i.in_z),
    .in_radius_i     (in_i.in_radius),
    .center_x_o      (out_o.center_x),
    .center_y_o      (out_o.center_y),
    .center_z_o      (out_o.center_z),
    .sphere_radius_o (out_o.sphere_radius),
    .overlaps_o      (out_o.overlaps),
    .growth_o        (out_o.growth)
  );

endmodule

>>> rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Bounding sphere accumulator controller
// Sequences the distance, square root, divide and center move steps.
// ----------------------------------------------------------------------------
module bsa_ctrl #(
  parameter int unsigned FRAC_BITS = bsa_pkg::FracBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bsa_pkg::sts_t sts_i,
  output bsa_pkg::cmd_t cmd_o
);

  bsa_pkg::state_e                 state_q, state_d;
  logic [bsa_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  logic                            sqrt_last, div_last;

  assign sqrt_last = (cnt_q == bsa_pkg::CntW'(bsa_pkg::SqrtSteps - 1));
  assign div_last  = (cnt_q == bsa_pkg::CntW'(FRAC_BITS));

  always_comb begin
    state_d = state_q;
    case (state_q)
      bsa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bsa_pkg::S_DIFF;
      end
      bsa_pkg::S_DIFF: begin
        case (sts_i.op)
          bsa_pkg::OP_RESET_PT: state_d = bsa_pkg::S_PT;
          bsa_pkg::OP_GROW_PT:  state_d = sts_i.cur_empty ? bsa_pkg::S_PT : bsa_pkg::S_MX;
          bsa_pkg::OP_GROW_SPH: begin
            if (sts_i.in_empty)       state_d = bsa_pkg::S_FIN;
            else if (sts_i.cur_empty) state_d = bsa_pkg::S_CP;
            else                      state_d = bsa_pkg::S_MX;
          end
          default: begin
            state_d = (sts_i.cur_empty || sts_i.in_empty) ? bsa_pkg::S_GE : bsa_pkg::S_MX;
          end
        endcase
      end
      bsa_pkg::S_PT, bsa_pkg::S_CP, bsa_pkg::S_GE, bsa_pkg::S_GR,
      bsa_pkg::S_TW: state_d = bsa_pkg::S_FIN;
      bsa_pkg::S_MX: state_d = bsa_pkg::S_MY;
      bsa_pkg::S_MY: state_d = bsa_pkg::S_MZ;
      bsa_pkg::S_MZ: state_d = bsa_pkg::S_MA;
      bsa_pkg::S_MA: state_d = bsa_pkg::S_MB;
      bsa_pkg::S_MB: state_d = bsa_pkg::S_MC;
      bsa_pkg::S_MC: begin
        if (!sts_i.cont) begin
          state_d = bsa_pkg::S_SQRT;
        end else begin
          case (sts_i.op)
            bsa_pkg::OP_GROW_SPH: state_d = sts_i.in_gt_cur ? bsa_pkg::S_CP : bsa_pkg::S_FIN;
            bsa_pkg::OP_QUERY:    state_d = bsa_pkg::S_GE;
            default:              state_d = bsa_pkg::S_FIN;
          endcase
        end
      end
      bsa_pkg::S_SQRT: begin
        if (sqrt_last) state_d = bsa_pkg::S_NR;
      end
      bsa_pkg::S_NR: begin
        state_d = (sts_i.op == bsa_pkg::OP_QUERY) ? bsa_pkg::S_GR : bsa_pkg::S_DINIT;
      end
      bsa_pkg::S_DINIT: state_d = bsa_pkg::S_DIV;
      bsa_pkg::S_DIV: begin
        if (div_last) state_d = bsa_pkg::S_TX;
      end
      bsa_pkg::S_TX: state_d = bsa_pkg::S_TY;
      bsa_pkg::S_TY: state_d = bsa_pkg::S_TZ;
      bsa_pkg::S_TZ: state_d = bsa_pkg::S_TW;
      bsa_pkg::S_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = bsa_pkg::S_IDLE;
      end
      default: state_d = bsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = bsa_pkg::MUL_DX;
    cmd_o.acc_op    = bsa_pkg::ACC_HOLD;
    cmd_o.upd       = bsa_pkg::UPD_NONE;
    cmd_o.gr_sel    = bsa_pkg::GR_HOLD;
    case (state_q)
      bsa_pkg::S_IDLE: cmd_o.load_in = in_valid_i;
      bsa_pkg::S_DIFF: cmd_o.diff_en = 1'b1;
      bsa_pkg::S_PT:   cmd_o.upd = bsa_pkg::UPD_POINT;
      bsa_pkg::S_CP:   cmd_o.upd = bsa_pkg::UPD_COPY;
      bsa_pkg::S_GE: begin
        cmd_o.gr_sel = (sts_i.cur_empty || (!sts_i.in_empty && sts_i.in_gt_cur)) ?
                       bsa_pkg::GR_IN : bsa_pkg::GR_CUR;
      end
      bsa_pkg::S_MX:   cmd_o.mul_sel = bsa_pkg::MUL_DX;
      bsa_pkg::S_MY: begin
        cmd_o.mul_sel = bsa_pkg::MUL_DY;
        cmd_o.acc_op  = bsa_pkg::ACC_LOAD;
      end
      bsa_pkg::S_MZ: begin
        cmd_o.mul_sel = bsa_pkg::MUL_DZ;
        cmd_o.acc_op  = bsa_pkg::ACC_ADD;
      end
      bsa_pkg::S_MA: begin
        cmd_o.mul_sel = (sts_i.op == bsa_pkg::OP_GROW_PT) ? bsa_pkg::MUL_R : bsa_pkg::MUL_RD;
        cmd_o.acc_op  = bsa_pkg::ACC_ADD;
      end
      bsa_pkg::S_MB: begin
        cmd_o.mul_sel = bsa_pkg::MUL_SUM;
        cmd_o.cont_en = 1'b1;
      end
      bsa_pkg::S_MC: begin
        cmd_o.ov_en     = 1'b1;
        cmd_o.sqrt_init = 1'b1;
      end
      bsa_pkg::S_SQRT:  cmd_o.sqrt_step = 1'b1;
      bsa_pkg::S_NR:    cmd_o.g_en = 1'b1;
      bsa_pkg::S_GR:    cmd_o.gr_sel = bsa_pkg::GR_NR;
      bsa_pkg::S_DINIT: cmd_o.div_init = 1'b1;
      bsa_pkg::S_DIV:   cmd_o.div_step = 1'b1;
      bsa_pkg::S_TX:    cmd_o.mul_sel = bsa_pkg::MUL_TX;
      bsa_pkg::S_TY: begin
        cmd_o.mul_sel = bsa_pkg::MUL_TY;
        cmd_o.upd     = bsa_pkg::UPD_X;
      end
      bsa_pkg::S_TZ: begin
        cmd_o.mul_sel = bsa_pkg::MUL_TZ;
        cmd_o.upd     = bsa_pkg::UPD_Y;
      end
      bsa_pkg::S_TW:    cmd_o.upd = bsa_pkg::UPD_Z;
      bsa_pkg::S_FIN:   cmd_o.load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if (state_q == bsa_pkg::S_SQRT) begin
      cnt_d = sqrt_last ? '0 : cnt_q + 1'b1;
    end else if (state_q == bsa_pkg::S_DIV) begin
      cnt_d = div_last ? '0 : cnt_q + 1'b1;
    end
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign in_ready_o  = (state_q == bsa_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsa_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == bsa_pkg::S_DIFF))
    else $error("accepted item did not start");
  a_sqrt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsa_pkg::S_SQRT) |-> (cnt_q < bsa_pkg::CntW'(bsa_pkg::SqrtSteps)))
    else $error("square root step count overrun");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsa_pkg::S_DIV) |-> (cnt_q <= bsa_pkg::CntW'(FRAC_BITS)))
    else $error("divide step count overrun");
`endif

endmodule

>>> rtl/bsa_datapath.sv
// ----------------------------------------------------------------------------
// Bounding sphere accumulator datapath
// Sphere state, shared multiplier, digit square root, divider and result regs.
// ----------------------------------------------------------------------------
module bsa_datapath #(
  parameter int unsigned FRAC_BITS = bsa_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsa_pkg::cmd_t      cmd_i,
  output bsa_pkg::sts_t      sts_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  input  logic signed [31:0] in_radius_i,
  output logic signed [31:0] center_x_o,
  output logic signed [31:0] center_y_o,
  output logic signed [31:0] center_z_o,
  output logic signed [31:0] sphere_radius_o,
  output logic               overlaps_o,
  output logic signed [31:0] growth_o
);

  localparam int unsigned MW = bsa_pkg::MagW;
  localparam int unsigned PW = bsa_pkg::ProdW;
  localparam int unsigned RW = bsa_pkg::RemW;
  localparam int unsigned GW = bsa_pkg::GrowW;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  function automatic logic [MW-1:0] mag33(input logic signed [MW-1:0] v);
    return v[MW-1] ? (~v + 1'b1) : v;
  endfunction

  bsa_pkg::op_e       op_q;
  logic signed [31:0] in_x_q, in_y_q, in_z_q, in_r_q;
  logic signed [31:0] ctr_x_q, ctr_y_q, ctr_z_q, ctr_r_q;
  logic [MW-1:0]      mdx_q, mdy_q, mdz_q, mrd_q, sum_q;
  logic               sdx_q, sdy_q, sdz_q;
  logic [PW-1:0]      prod_q, acc_q, rad_q;
  logic               cont_q, ov_q;
  logic [RW-1:0]      rem_q;
  logic [MW-1:0]      root_q;
  logic [GW-1:0]      g_q, drem_q;
  logic [FRAC_BITS:0] quo_q;
  logic signed [31:0] gr_q;

  logic signed [MW-1:0] dx, dy, dz, rd, rsum;
  logic [MW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        prod_d;
  logic [RW-1:0]        rem_sh, trial;
  logic [GW-1:0]        dist_w, sph_sum, nr, g_d;
  logic [MW-1:0]        off;
  logic signed [35:0]   r_grown, mr_ext;
  logic signed [31:0]   mr;

  assign dx   = {in_x_q[31], in_x_q} - {ctr_x_q[31], ctr_x_q};
  assign dy   = {in_y_q[31], in_y_q} - {ctr_y_q[31], ctr_y_q};
  assign dz   = {in_z_q[31], in_z_q} - {ctr_z_q[31], ctr_z_q};
  assign rd   = {in_r_q[31], in_r_q} - {ctr_r_q[31], ctr_r_q};
  assign rsum = {in_r_q[31], in_r_q} + {ctr_r_q[31], ctr_r_q};

  always_comb begin
    mul_a = mdx_q;
    mul_b = mdx_q;
    case (cmd_i.mul_sel)
      bsa_pkg::MUL_DX:  begin mul_a = mdx_q; mul_b = mdx_q; end
      bsa_pkg::MUL_DY:  begin mul_a = mdy_q; mul_b = mdy_q; end
      bsa_pkg::MUL_DZ:  begin mul_a = mdz_q; mul_b = mdz_q; end
      bsa_pkg::MUL_R:   begin mul_a = {1'b0, ctr_r_q}; mul_b = {1'b0, ctr_r_q}; end
      bsa_pkg::MUL_RD:  begin mul_a = mrd_q; mul_b = mrd_q; end
      bsa_pkg::MUL_SUM: begin mul_a = sum_q; mul_b = sum_q; end
      bsa_pkg::MUL_TX:  begin mul_a = mdx_q; mul_b = MW'(quo_q); end
      bsa_pkg::MUL_TY:  begin mul_a = mdy_q; mul_b = MW'(quo_q); end
      bsa_pkg::MUL_TZ:  begin mul_a = mdz_q; mul_b = MW'(quo_q); end
      default: ;
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  assign rem_sh = {rem_q[RW-3:0], rad_q[PW-1:PW-2]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign dist_w  = GW'(root_q);
  assign sph_sum = GW'($unsigned(ctr_r_q)) + GW'($unsigned(in_r_q)) + dist_w;
  assign nr      = sph_sum >> 1;
  assign g_d     = (op_q == bsa_pkg::OP_GROW_PT) ?
                   ((dist_w - GW'($unsigned(ctr_r_q))) >> 1) :
                   (nr - GW'($unsigned(ctr_r_q)));

  assign off     = prod_q[FRAC_BITS +: MW];
  assign r_grown = 36'(ctr_r_q) + $signed({1'b0, g_q});

  always_comb begin
    case (cmd_i.gr_sel)
      bsa_pkg::GR_IN:  mr = in_r_q;
      bsa_pkg::GR_NR:  mr = sat32(r_grown);
      default:         mr = ctr_r_q;
    endcase
  end
  assign mr_ext = 36'(mr) - 36'(ctr_r_q);

  function automatic logic signed [31:0] move1(input logic signed [31:0] c,
                                              input logic neg, input logic [MW-1:0] o);
    logic signed [35:0] ce;
    logic signed [35:0] oe;
    ce = 36'(c);
    oe = $signed({3'b000, o});
    return sat32(neg ? ce - oe : ce + oe);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q <= '0;
      ctr_y_q <= '0;
      ctr_z_q <= '0;
      ctr_r_q <= -32'sd1;
    end else begin
      case (cmd_i.upd)
        bsa_pkg::UPD_POINT: begin
          ctr_x_q <= in_x_q;
          ctr_y_q <= in_y_q;
          ctr_z_q <= in_z_q;
          ctr_r_q <= '0;
        end
        bsa_pkg::UPD_COPY: begin
          ctr_x_q <= in_x_q;
          ctr_y_q <= in_y_q;
          ctr_z_q <= in_z_q;
          ctr_r_q <= in_r_q;
        end
        bsa_pkg::UPD_X: ctr_x_q <= move1(ctr_x_q, sdx_q, off);
        bsa_pkg::UPD_Y: ctr_y_q <= move1(ctr_y_q, sdy_q, off);
        bsa_pkg::UPD_Z: begin
          ctr_z_q <= move1(ctr_z_q, sdz_q, off);
          ctr_r_q <= sat32(r_grown);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= bsa_pkg::op_e'(op_i);
      in_x_q <= in_x_i;
      in_y_q <= in_y_i;
      in_z_q <= in_z_i;
      in_r_q <= in_radius_i;
      ov_q   <= 1'b0;
    end else if (cmd_i.ov_en) begin
      ov_q <= !(prod_q <= acc_q);
    end
    if (cmd_i.diff_en) begin
      mdx_q <= mag33(dx);
      mdy_q <= mag33(dy);
      mdz_q <= mag33(dz);
      sdx_q <= dx[MW-1];
      sdy_q <= dy[MW-1];
      sdz_q <= dz[MW-1];
      mrd_q <= mag33(rd);
      sum_q <= rsum;
    end
    prod_q <= prod_d;
    case (cmd_i.acc_op)
      bsa_pkg::ACC_LOAD: acc_q <= prod_q;
      bsa_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      default: ;
    endcase
    if (cmd_i.cont_en) cont_q <= (acc_q <= prod_q);
    if (cmd_i.sqrt_init) begin
      rad_q  <= acc_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[PW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[MW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[MW-2:0], 1'b0};
      end
    end
    if (cmd_i.g_en) g_q <= g_d;
    if (cmd_i.div_init) begin
      drem_q <= g_q;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (drem_q >= dist_w) begin
        drem_q <= (drem_q - dist_w) << 1;
        quo_q  <= {quo_q[FRAC_BITS-1:0], 1'b1};
      end else begin
        drem_q <= drem_q << 1;
        quo_q  <= {quo_q[FRAC_BITS-1:0], 1'b0};
      end
    end
    if (cmd_i.gr_sel != bsa_pkg::GR_HOLD) gr_q <= sat32(mr_ext);
    if (cmd_i.load_out) begin
      center_x_o      <= ctr_x_q;
      center_y_o      <= ctr_y_q;
      center_z_o      <= ctr_z_q;
      sphere_radius_o <= ctr_r_q;
      overlaps_o      <= (op_q == bsa_pkg::OP_QUERY) & ov_q;
      growth_o        <= (op_q == bsa_pkg::OP_QUERY) ? gr_q : '0;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.cur_empty = ctr_r_q[31];
  assign sts_o.in_empty  = in_r_q[31];
  assign sts_o.in_gt_cur = (in_r_q > ctr_r_q);
  assign sts_o.cont      = cont_q;

endmodule
